// ----- design/pru_pkg.sv -----
// Shared types and constants of the PNG row unfilter unit.
package pru_pkg;

    // Filter type codes carried in the first byte of each scanline
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // Highest filter type code that is defined
    localparam logic [7:0] FILT_MAX_CODE = 8'd4;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd2;

    // Neighbor bytes handed to the predictor
    typedef struct packed {
        t_filter    kind;
        logic [7:0] left;
        logic [7:0] up;
        logic [7:0] upleft;
    } t_pred_in;

endpackage

// ----- design/pru_predict.sv -----
// Predictor of the PNG row unfilter unit: None, Sub, Up, Average and Paeth.
module pru_predict (
    input  pru_pkg::t_pred_in i_pred,
    output logic [7:0]        o_pred
);

    function automatic logic [9:0] abs11(input logic signed [10:0] v);
        logic signed [10:0] m;
        m = (v < 0) ? -v : v;
        return m[9:0];
    endfunction

    logic signed [10:0] w_a;
    logic signed [10:0] w_b;
    logic signed [10:0] w_c;
    logic signed [10:0] w_p;
    logic [9:0]         w_pa;
    logic [9:0]         w_pb;
    logic [9:0]         w_pc;
    logic [7:0]         w_paeth;
    logic [8:0]         w_sum;

    assign w_a = signed'({3'b000, i_pred.left});
    assign w_b = signed'({3'b000, i_pred.up});
    assign w_c = signed'({3'b000, i_pred.upleft});
    assign w_p = w_a + w_b - w_c;

    assign w_pa = abs11(w_p - w_a);
    assign w_pb = abs11(w_p - w_b);
    assign w_pc = abs11(w_p - w_c);

    // Ties go to left, then to up
    always_comb begin
        if ((w_pa <= w_pb) && (w_pa <= w_pc)) begin
            w_paeth = i_pred.left;
        end else if (w_pb <= w_pc) begin
            w_paeth = i_pred.up;
        end else begin
            w_paeth = i_pred.upleft;
        end
    end

    assign w_sum = {1'b0, i_pred.left} + {1'b0, i_pred.up};

    always_comb begin
        case (i_pred.kind)
            pru_pkg::FILT_NONE:  o_pred = 8'd0;
            pru_pkg::FILT_SUB:   o_pred = i_pred.left;
            pru_pkg::FILT_UP:    o_pred = i_pred.up;
            pru_pkg::FILT_AVG:   o_pred = w_sum[8:1];
            pru_pkg::FILT_PAETH: o_pred = w_paeth;
            default:             o_pred = 8'd0;
        endcase
    end

endmodule

// ----- design/png_row_unfilter_unit.sv -----
// Top level of the PNG row unfilter unit: scanline reconstruction from the inflated stream.
//
// Slave stream: one inflated byte per transaction; each scanline is a filter-type
// byte followed by row_bytes filtered bytes. Filter bytes and rows past
// image_rows give no result. Master stream: one reconstructed byte per data
// byte, tlast on the final byte of a scanline, tuser carries the error status
// and the final-byte-of-image mark.
// The user must write configuration via the plain write port only while the block is idle; it is not checked.
// Throughput: one input byte per cycle while the master side is not stalled, set by the single
// pass from the input register through the predictor into the result register; the line store
// is read at accept and written when an error-free data byte moves into the result register.
// Path: a data byte accepted into the input register passes through the predictor into the
// result register, which drives the master side.
// Receiver stall: the result register and the input register each hold one
// transaction, then the slave tready drops until the master side drains.
// Reset: control state, history bytes and the sticky error clear synchronously;
// the line store is not cleared, and the first row ignores what it reads from it.
module png_row_unfilter_unit #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [pru_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [pru_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // slave stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,   // [7:0] stream_byte
    // master stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata,   // [7:0] pixel_byte
    output logic                           o_m_axis_tlast,   // row_last
    output logic [1:0]                     o_m_axis_tuser    // [0] status, [1] image_last
);

    localparam int PW = $clog2(MAX_ROW_BYTES + 1);
    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // configuration registers
    logic [13:0] r_row_bytes;
    logic [3:0]  r_pixel_size;
    logic [15:0] r_image_rows;

    // front end position tracking
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [15:0]   r_row;
    logic [15:0]   n_row;
    logic [SW-1:0] r_mod [MAX_PIXEL_BYTES];

    logic [PW-1:0] w_len;
    logic [3:0]    w_bpp;
    logic [PW-1:0] w_idx;
    logic          w_is_filter;
    logic          w_rlast;
    logic          w_ilast;
    logic          w_first_px;
    logic [SW-1:0] w_slot;
    logic          w_accept;

    // input stage
    logic          r_a_valid;
    logic [7:0]    r_a_byte;
    logic          r_a_is_filter;
    logic          r_a_inside;
    logic          r_a_first_row;
    logic [AW-1:0] r_a_addr;
    logic [SW-1:0] r_a_slot;
    logic          r_a_first_px;
    logic          r_a_rlast;
    logic          r_a_ilast;
    logic [7:0]    r_up;

    // reconstruction state
    pru_pkg::t_filter r_kind;
    logic             r_err;
    logic [7:0]       r_left   [MAX_PIXEL_BYTES];
    logic [7:0]       r_upleft [MAX_PIXEL_BYTES];
    logic [7:0]       r_line   [MAX_ROW_BYTES];

    logic               w_has_result;
    logic               w_out_free;
    logic               w_advance;
    logic               w_store;
    pru_pkg::t_pred_in  w_pred_in;
    logic [7:0]         w_pred;
    logic [7:0]         w_pix;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_pix;
    logic       r_out_status;
    logic       r_out_rlast;
    logic       r_out_ilast;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes  <= 14'd1;
            r_pixel_size <= 4'd1;
            r_image_rows <= 16'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                pru_pkg::CFG_ROW_BYTES:  r_row_bytes  <= i_cfg_wdata[13:0];
                pru_pkg::CFG_PIXEL_SIZE: r_pixel_size <= i_cfg_wdata[3:0];
                pru_pkg::CFG_IMAGE_ROWS: r_image_rows <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // clamp the row length and pixel size into their supported ranges
    always_comb begin
        if (r_row_bytes == 14'd0) begin
            w_len = PW'(1);
        end else if (32'(r_row_bytes) > 32'(MAX_ROW_BYTES)) begin
            w_len = PW'(MAX_ROW_BYTES);
        end else begin
            w_len = PW'(r_row_bytes);
        end
        if (r_pixel_size == 4'd0) begin
            w_bpp = 4'd1;
        end else if (32'(r_pixel_size) > 32'(MAX_PIXEL_BYTES)) begin
            w_bpp = 4'(MAX_PIXEL_BYTES);
        end else begin
            w_bpp = r_pixel_size;
        end
    end

    // ---------------- front end ----------------
    assign w_is_filter = (r_pos == '0);
    assign w_idx       = r_pos - PW'(1);
    assign w_rlast     = (r_pos >= w_len);
    assign w_ilast     = w_rlast && (({1'b0, r_row} + 17'd1) == {1'b0, r_image_rows});
    assign w_first_px  = (32'(w_idx) < 32'(w_bpp));
    // position modulo the pixel size, one counter per possible size
    assign w_slot      = r_mod[SW'(w_bpp - 4'd1)];

    always_comb begin
        if (w_is_filter) begin
            n_pos = PW'(1);
        end else if (w_rlast) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + PW'(1);
        end
        if (!w_is_filter && w_rlast && (r_row != 16'hFFFF)) begin
            n_row = r_row + 16'd1;
        end else begin
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_row <= '0;
            for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
                r_mod[m] <= '0;
            end
        end else if (w_accept) begin
            r_pos <= n_pos;
            r_row <= n_row;
            if (!w_is_filter) begin
                for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
                    if (w_rlast || (r_mod[m] == SW'(m))) begin
                        r_mod[m] <= '0;
                    end else begin
                        r_mod[m] <= r_mod[m] + SW'(1);
                    end
                end
            end
        end
    end

    // ---------------- handshake ----------------
    assign w_has_result    = !r_a_is_filter && r_a_inside;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_advance       = r_a_valid && (!w_has_result || w_out_free);
    assign o_s_axis_tready = !r_a_valid || w_advance;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- input stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_accept) begin
            r_a_valid <= 1'b1;
        end else if (w_advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_byte      <= i_s_axis_tdata;
            r_a_is_filter <= w_is_filter;
            r_a_inside    <= (r_row < r_image_rows);
            r_a_first_row <= (r_row == 16'd0);
            r_a_addr      <= w_idx[AW-1:0];
            r_a_slot      <= w_slot;
            r_a_first_px  <= w_first_px;
            r_a_rlast     <= w_rlast;
            r_a_ilast     <= w_ilast;
        end
    end

    // line store: read at accept, written back when an error-free data byte leaves the input stage
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_is_filter) begin
            r_up <= r_line[w_idx[AW-1:0]];
        end
        if (w_store) begin
            r_line[r_a_addr] <= w_pix;
        end
    end

    // ---------------- reconstruction ----------------
    assign w_pred_in.kind   = r_kind;
    assign w_pred_in.up     = r_a_first_row ? 8'd0 : r_up;
    assign w_pred_in.left   = r_a_first_px ? 8'd0 : r_left[r_a_slot];
    assign w_pred_in.upleft = r_a_first_px ? 8'd0 : r_upleft[r_a_slot];

    pru_predict u_predict (
        .i_pred (w_pred_in),
        .o_pred (w_pred)
    );

    assign w_pix   = r_a_byte + w_pred;
    assign w_store = w_advance && w_has_result && !r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= pru_pkg::FILT_NONE;
            r_err  <= 1'b0;
            for (int s = 0; s < MAX_PIXEL_BYTES; s++) begin
                r_left[s]   <= 8'd0;
                r_upleft[s] <= 8'd0;
            end
        end else if (w_advance) begin
            if (r_a_is_filter) begin
                // filter bytes of rows past the image are not checked
                if (r_a_inside && !r_err) begin
                    if (r_a_byte > pru_pkg::FILT_MAX_CODE) begin
                        r_err <= 1'b1;
                    end else begin
                        r_kind <= pru_pkg::t_filter'(r_a_byte[2:0]);
                    end
                end
            end else if (w_store) begin
                r_left[r_a_slot]   <= w_pix;
                r_upleft[r_a_slot] <= w_pred_in.up;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out_pix    <= r_err ? 8'd0 : w_pix;
            r_out_status <= r_err ? pru_pkg::STATUS_ERR : pru_pkg::STATUS_OK;
            r_out_rlast  <= r_a_rlast;
            r_out_ilast  <= r_a_ilast;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pix;
    assign o_m_axis_tlast  = r_out_rlast;
    assign o_m_axis_tuser  = {r_out_ilast, r_out_status};

    // ---------------- assertions ----------------
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("unknown-filter error flag cleared without reset");

    a_err_zero_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == pru_pkg::STATUS_ERR)) |-> (r_out_pix == 8'd0))
        else $error("error result carries a nonzero pixel byte");

    a_image_last_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ilast) |-> r_out_rlast)
        else $error("image end marked on a byte that does not end a row");

    a_filter_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_filter) |=> (r_pos == PW'(1)))
        else $error("position did not move to the first data byte after a filter byte");

    a_row_end_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_filter && w_rlast) |=> (r_pos == '0))
        else $error("position did not return to the filter byte after a row end");

endmodule
